// ===== rtl/kcc_pkg.sv =====
// ----------------------------------------------------------------------------
// kcc_pkg
// Shared constants, codes, command/status types, the element classifier and
// element addressing for the chi step constraint checker.
// ----------------------------------------------------------------------------
package kcc_pkg;

  // Geometry of the permutation state
  localparam int LANE_BITS  = 64;
  localparam int NUM_LANES  = 25;
  localparam int ROW_LANES  = 5;
  localparam int STATE_BITS = NUM_LANES * LANE_BITS;

  // Field widths
  localparam int IDX_W   = 11;
  localparam int COEFF_W = 64;
  localparam int SEL_W   = 2;
  localparam int CODE_W  = 3;
  localparam int ROW_W   = 3;
  localparam int Z_W     = (LANE_BITS > 1) ? $clog2(LANE_BITS) : 1;

  // Goldilocks modulus and its successor
  localparam logic [COEFF_W-1:0] GOLD_P      = 64'hFFFF_FFFF_0000_0001;
  localparam logic [COEFF_W-1:0] GOLD_P_PLUS = 64'hFFFF_FFFF_0000_0002;

  // Element classes
  localparam logic [1:0] CLS_ZERO  = 2'd0;
  localparam logic [1:0] CLS_ONE   = 2'd1;
  localparam logic [1:0] CLS_OTHER = 2'd2;

  // Request function codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_CHECK = 1'b1;

  // Target array codes
  localparam logic [SEL_W-1:0] SEL_INPUT  = 2'd0;
  localparam logic [SEL_W-1:0] SEL_OUTPUT = 2'd1;
  localparam logic [SEL_W-1:0] SEL_HELPER = 2'd2;

  // Failure codes
  localparam logic [CODE_W-1:0] FAIL_NONE    = 3'd0;
  localparam logic [CODE_W-1:0] FAIL_IN_BIN  = 3'd1;
  localparam logic [CODE_W-1:0] FAIL_OUT_BIN = 3'd2;
  localparam logic [CODE_W-1:0] FAIL_HLP_BIN = 3'd3;
  localparam logic [CODE_W-1:0] FAIL_HLP_EQ  = 3'd4;
  localparam logic [CODE_W-1:0] FAIL_XOR_EQ  = 3'd5;

  // Scan passes: binary and xor checks first, then the helper formula
  typedef enum logic {
    MODE_BIN = 1'b0,
    MODE_HLP = 1'b1
  } scan_mode_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       cnt_clear;
    logic       flag_clear;
    logic       step;
    scan_mode_t mode;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic             last;
    logic             bad_in;
    logic             bad_out;
    logic             bad_hlp;
    logic             hlp_fail;
    logic [IDX_W-1:0] hlp_idx;
    logic             xor_fail;
    logic [IDX_W-1:0] xor_idx;
  } dp_status_t;

  // Class of an element given as two coordinates; p reads as zero
  function automatic logic [1:0] classify(input logic [COEFF_W-1:0] lo,
                                          input logic [COEFF_W-1:0] hi);
    logic hi_zero;
    logic lo_zero;
    logic lo_one;
    hi_zero = (hi == '0) || (hi == GOLD_P);
    lo_zero = (lo == '0) || (lo == GOLD_P);
    lo_one  = (lo == COEFF_W'(1)) || (lo == GOLD_P_PLUS);
    if (!hi_zero) begin
      return CLS_OTHER;
    end else if (lo_zero) begin
      return CLS_ZERO;
    end else if (lo_one) begin
      return CLS_ONE;
    end
    return CLS_OTHER;
  endfunction

  // Element index of lane (row, col) and bit z
  function automatic logic [IDX_W-1:0] elem_addr(input logic [ROW_W-1:0] row,
                                                 input logic [ROW_W-1:0] col,
                                                 input logic [Z_W-1:0]   z);
    return (IDX_W'(row) * IDX_W'(ROW_LANES) + IDX_W'(col)) * IDX_W'(LANE_BITS)
           + IDX_W'(z);
  endfunction

endpackage

// ===== rtl/kcc_req_if.sv =====
// ----------------------------------------------------------------------------
// kcc_req_if
// Request channel: load one witness element or run the constraint check.
// ----------------------------------------------------------------------------
interface kcc_req_if
  import kcc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               func;
  logic [SEL_W-1:0]   array_select;
  logic [IDX_W-1:0]   position;
  logic [COEFF_W-1:0] coeff_low;
  logic [COEFF_W-1:0] coeff_high;

  modport source (
    output valid, func, array_select, position, coeff_low, coeff_high,
    input  ready
  );
  modport sink (
    input  valid, func, array_select, position, coeff_low, coeff_high,
    output ready
  );
endinterface

// ===== rtl/kcc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// kcc_rsp_if
// Response channel: outcome of one constraint check.
// ----------------------------------------------------------------------------
interface kcc_rsp_if
  import kcc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              passed;
  logic [CODE_W-1:0] fail_code;
  logic [IDX_W-1:0]  fail_index;

  modport source (
    output valid, passed, fail_code, fail_index,
    input  ready
  );
  modport sink (
    input  valid, passed, fail_code, fail_index,
    output ready
  );
endinterface

// ===== rtl/kcc_datapath.sv =====
// ----------------------------------------------------------------------------
// kcc_datapath
// Class memories, scan address counters, one-stage read pipeline and the
// sticky failure flags of the constraint scans.
// ----------------------------------------------------------------------------
module kcc_datapath
  import kcc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  input  logic [SEL_W-1:0]   array_select,
  input  logic [IDX_W-1:0]   position,
  input  logic [COEFF_W-1:0] coeff_low,
  input  logic [COEFF_W-1:0] coeff_high,
  output dp_status_t         status
);

  logic [1:0] input_mem  [STATE_BITS];
  logic [1:0] output_mem [STATE_BITS];
  logic [1:0] helper_mem [STATE_BITS];

  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] col;
  logic [Z_W-1:0]   z;
  logic [ROW_W-1:0] col_n1;
  logic [ROW_W-1:0] col_n2;
  logic [IDX_W-1:0] addr_idx;
  logic [IDX_W-1:0] addr_n1;
  logic [IDX_W-1:0] addr_n2;
  logic [IDX_W-1:0] addr_a;
  logic             scan_last;

  logic [1:0]       load_cls;
  logic             load_ok;

  logic             rd_valid;
  scan_mode_t       rd_mode;
  logic [IDX_W-1:0] rd_idx;
  logic [1:0]       rd_in_a;
  logic [1:0]       rd_in_b;
  logic [1:0]       rd_out;
  logic [1:0]       rd_hlp;

  logic             bad_in;
  logic             bad_out;
  logic             bad_hlp;
  logic             hlp_fail;
  logic [IDX_W-1:0] hlp_idx;
  logic             xor_fail;
  logic [IDX_W-1:0] xor_idx;

  logic [1:0]       want_xor;
  logic [1:0]       want_hlp;

  // Neighbor columns, wrapping within the row
  assign col_n1 = (col == ROW_W'(ROW_LANES - 1)) ? '0 : col + ROW_W'(1);
  assign col_n2 = (col >= ROW_W'(ROW_LANES - 2)) ? col - ROW_W'(ROW_LANES - 2)
                                                 : col + ROW_W'(2);

  assign addr_idx  = elem_addr(row, col,    z);
  assign addr_n1   = elem_addr(row, col_n1, z);
  assign addr_n2   = elem_addr(row, col_n2, z);
  assign addr_a    = (cmd.mode == MODE_HLP) ? addr_n1 : addr_idx;
  assign scan_last = (row == ROW_W'(ROW_LANES - 1)) &&
                     (col == ROW_W'(ROW_LANES - 1)) &&
                     (z == Z_W'(LANE_BITS - 1));

  // Classify the element of a load request
  assign load_cls = classify(coeff_low, coeff_high);
  assign load_ok  = cmd.load && (position < IDX_W'(STATE_BITS));

  // Advance the scan counters lane by lane, bit by bit
  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
      z   <= '0;
    end else if (cmd.cnt_clear) begin
      row <= '0;
      col <= '0;
      z   <= '0;
    end else if (cmd.step) begin
      if (z == Z_W'(LANE_BITS - 1)) begin
        z <= '0;
        if (col == ROW_W'(ROW_LANES - 1)) begin
          col <= '0;
          row <= (row == ROW_W'(ROW_LANES - 1)) ? '0 : row + ROW_W'(1);
        end else begin
          col <= col + ROW_W'(1);
        end
      end else begin
        z <= z + Z_W'(1);
      end
    end
  end

  // Input memory: one write port, two read ports
  always_ff @(posedge clk) begin
    if (load_ok && (array_select == SEL_INPUT)) begin
      input_mem[position] <= load_cls;
    end
    rd_in_a <= input_mem[addr_a];
    rd_in_b <= input_mem[addr_n2];
  end

  // Output memory
  always_ff @(posedge clk) begin
    if (load_ok && (array_select == SEL_OUTPUT)) begin
      output_mem[position] <= load_cls;
    end
    rd_out <= output_mem[addr_idx];
  end

  // Helper memory
  always_ff @(posedge clk) begin
    if (load_ok && (array_select == SEL_HELPER)) begin
      helper_mem[position] <= load_cls;
    end
    rd_hlp <= helper_mem[addr_idx];
  end

  // Track which read data is in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.step;
    end
    rd_mode <= cmd.mode;
    rd_idx  <= addr_idx;
  end

  assign want_xor = rd_in_a ^ rd_hlp;
  assign want_hlp = (rd_in_a ^ CLS_ONE) & rd_in_b;

  // Accumulate failures; keep only the first formula failure of each kind
  always_ff @(posedge clk) begin
    if (rst || cmd.flag_clear) begin
      bad_in   <= 1'b0;
      bad_out  <= 1'b0;
      bad_hlp  <= 1'b0;
      hlp_fail <= 1'b0;
      xor_fail <= 1'b0;
      hlp_idx  <= '0;
      xor_idx  <= '0;
    end else if (rd_valid) begin
      if (rd_mode == MODE_BIN) begin
        if (rd_in_a > CLS_ONE) begin
          bad_in <= 1'b1;
        end
        if (rd_out > CLS_ONE) begin
          bad_out <= 1'b1;
        end
        if (rd_hlp > CLS_ONE) begin
          bad_hlp <= 1'b1;
        end
        if (!xor_fail && (rd_out != want_xor)) begin
          xor_fail <= 1'b1;
          xor_idx  <= rd_idx;
        end
      end else begin
        if (!hlp_fail && (rd_hlp != want_hlp)) begin
          hlp_fail <= 1'b1;
          hlp_idx  <= rd_idx;
        end
      end
    end
  end

  assign status.last     = scan_last;
  assign status.bad_in   = bad_in;
  assign status.bad_out  = bad_out;
  assign status.bad_hlp  = bad_hlp;
  assign status.hlp_fail = hlp_fail;
  assign status.hlp_idx  = hlp_idx;
  assign status.xor_fail = xor_fail;
  assign status.xor_idx  = xor_idx;

  // A scan never overlaps a load
  a_no_load_in_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !cmd.step && !rd_valid)
    else $error("load request during a scan");

  // The first recorded formula failure stays put
  a_xor_idx_sticky: assert property (@(posedge clk) disable iff (rst)
    xor_fail && !cmd.flag_clear |=> xor_fail && $stable(xor_idx))
    else $error("xor failure index changed");

  a_hlp_idx_sticky: assert property (@(posedge clk) disable iff (rst)
    hlp_fail && !cmd.flag_clear |=> hlp_fail && $stable(hlp_idx))
    else $error("helper failure index changed");

endmodule

// ===== rtl/kcc_ctrl.sv =====
// ----------------------------------------------------------------------------
// kcc_ctrl
// Controller: accepts requests, sequences the two scan passes and holds the
// response register.
// ----------------------------------------------------------------------------
module kcc_ctrl
  import kcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_func,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output logic              passed,
  output logic [CODE_W-1:0] fail_code,
  output logic [IDX_W-1:0]  fail_index,
  output dp_cmd_t           cmd,
  input  dp_status_t        status
);

  typedef enum logic [2:0] {
    IDLE,
    SCAN_BIN,
    DRAIN_BIN,
    DECIDE_BIN,
    SCAN_HLP,
    DRAIN_HLP,
    DECIDE_HLP
  } state_t;

  state_t state;
  logic   accept;
  logic   rsp_free;
  logic   any_bad;
  logic   rsp_load;

  assign req_ready = (state == IDLE);
  assign accept    = req_valid && req_ready;
  assign rsp_free  = !rsp_valid || rsp_ready;
  assign any_bad   = status.bad_in || status.bad_out || status.bad_hlp;

  // Load the response register from a decision step
  assign rsp_load  = rsp_free && (((state == DECIDE_BIN) && any_bad) ||
                                  (state == DECIDE_HLP));

  // Issue datapath commands for the current state
  always_comb begin
    cmd      = '0;
    cmd.mode = MODE_BIN;
    case (state)
      IDLE: begin
        if (accept) begin
          if (req_func == FUNC_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.cnt_clear  = 1'b1;
            cmd.flag_clear = 1'b1;
          end
        end
      end
      SCAN_BIN: begin
        cmd.step = 1'b1;
      end
      DECIDE_BIN: begin
        cmd.cnt_clear = 1'b1;
      end
      SCAN_HLP: begin
        cmd.step = 1'b1;
        cmd.mode = MODE_HLP;
      end
      DRAIN_HLP: begin
        cmd.mode = MODE_HLP;
      end
      default: begin
      end
    endcase
  end

  // Hold state and the response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      rsp_valid  <= 1'b0;
      passed     <= 1'b0;
      fail_code  <= FAIL_NONE;
      fail_index <= '0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept && (req_func == FUNC_CHECK)) begin
            state <= SCAN_BIN;
          end
        end
        SCAN_BIN: begin
          if (status.last) begin
            state <= DRAIN_BIN;
          end
        end
        DRAIN_BIN: begin
          state <= DECIDE_BIN;
        end
        DECIDE_BIN: begin
          if (!any_bad) begin
            state <= SCAN_HLP;
          end else if (rsp_free) begin
            passed     <= 1'b0;
            fail_index <= '0;
            if (status.bad_in) begin
              fail_code <= FAIL_IN_BIN;
            end else if (status.bad_out) begin
              fail_code <= FAIL_OUT_BIN;
            end else begin
              fail_code <= FAIL_HLP_BIN;
            end
            state <= IDLE;
          end
        end
        SCAN_HLP: begin
          if (status.last) begin
            state <= DRAIN_HLP;
          end
        end
        DRAIN_HLP: begin
          state <= DECIDE_HLP;
        end
        DECIDE_HLP: begin
          if (rsp_free) begin
            if (status.hlp_fail) begin
              passed     <= 1'b0;
              fail_code  <= FAIL_HLP_EQ;
              fail_index <= status.hlp_idx;
            end else if (status.xor_fail) begin
              passed     <= 1'b0;
              fail_code  <= FAIL_XOR_EQ;
              fail_index <= status.xor_idx;
            end else begin
              passed     <= 1'b1;
              fail_code  <= FAIL_NONE;
              fail_index <= '0;
            end
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // A passing check carries no failure code
  a_pass_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && passed |-> fail_code == FAIL_NONE)
    else $error("pass reported with a failure code");

  // Only formula failures report an element index
  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (fail_code != FAIL_HLP_EQ) && (fail_code != FAIL_XOR_EQ)
      |-> fail_index == '0)
    else $error("index reported for a non-formula result");

  // A response only comes out of a decision step
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == DECIDE_BIN) || $past(state == DECIDE_HLP))
    else $error("response raised outside a decision step");

  // A check request keeps the block busy for the scan
  a_check_busy: assert property (@(posedge clk) disable iff (rst)
    accept && (req_func == FUNC_CHECK) |=> !req_ready ##1 !req_ready)
    else $error("request taken during a scan");

endmodule

// ===== rtl/keccak_chi_constraint_checker.sv =====
// ----------------------------------------------------------------------------
// keccak_chi_constraint_checker
// Load request: one per cycle while no check runs, written to the class
// memories, no response. Check request: one scan of 1600 elements (binary
// and xor checks), then, unless a binary check failed, a second scan for the
// helper formula; the response waits until the previous one is taken. One
// check at a time; the element rate of one per cycle is set by the single
// scan counter and the memory read ports. Reset clears control state only;
// the memories hold.
// ----------------------------------------------------------------------------
module keccak_chi_constraint_checker
  import kcc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  kcc_req_if.sink   req,
  kcc_rsp_if.source rsp
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequence requests and hold the response
  kcc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_func   (req.func),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .passed     (rsp.passed),
    .fail_code  (rsp.fail_code),
    .fail_index (rsp.fail_index),
    .cmd        (cmd),
    .status     (status)
  );

  // Store classes and run the scans
  kcc_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .array_select (req.array_select),
    .position     (req.position),
    .coeff_low    (req.coeff_low),
    .coeff_high   (req.coeff_high),
    .status       (status)
  );

endmodule

// ===== dv/keccak_chi_constraint_checker_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keccak_chi_constraint_checker_tb
// Fills the three class memories with an all-zero witness, walks a short
// table of directed requests, then runs random episodes: consistent
// witness rewrites, injected faults followed by a check and an undo, and
// requests the block must ignore. Every check response is compared with a
// table verdict or one computed from the bench copy of the class memories.
// ----------------------------------------------------------------------------
module keccak_chi_constraint_checker_tb;
  import kcc_pkg::*;

  localparam int RAND_ITEMS  = 1600;
  localparam int MIN_CHECKS  = 40;
  localparam int MAX_CHECKS  = 120;
  localparam int TAIL_CYCLES = 3300;
  localparam int LIMIT       = 3000000;

  // Array select code that names no array
  localparam logic [SEL_W-1:0] SEL_NONE = 2'd3;

  typedef struct packed {
    logic              passed;
    logic [CODE_W-1:0] code;
    logic [IDX_W-1:0]  fidx;
  } verdict_t;

  typedef struct packed {
    logic               func;
    logic [SEL_W-1:0]   sel;
    logic [IDX_W-1:0]   pos;
    logic [COEFF_W-1:0] lo;
    logic [COEFF_W-1:0] hi;
    logic               typed;
    verdict_t           want;
  } stim_row_t;

  typedef struct packed {
    logic [SEL_W-1:0] sel;
    logic [IDX_W-1:0] pos;
    logic [1:0]       cls;
  } undo_t;

  typedef enum int {
    FLT_IN_NB, FLT_OUT_NB, FLT_HLP_NB, FLT_IN_FLIP, FLT_HLP_FLIP, FLT_OUT_FLIP
  } fault_t;

  localparam verdict_t NO_VERDICT   = '0;
  localparam verdict_t PASS_VERDICT = '{1'b1, FAIL_NONE, IDX_W'(0)};

  logic clk;
  logic rst;

  kcc_req_if req_ch ();
  kcc_rsp_if rsp_ch ();

  keccak_chi_constraint_checker dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Bench copy of the class memories, indexed by array select
  logic [1:0] cls_mem [0:2][0:STATE_BITS-1];

  verdict_t  verdict_q [$];
  undo_t     undo_q [$];
  stim_row_t dir_tab [$];

  int n_items;
  int n_checks;
  int n_errors;
  int n_cycles;
  int snd_idle_pct;
  int rcv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic flag_error(input string what);
    n_errors++;
    if (n_errors <= 10) $display("ERROR: %s", what);
  endtask

  // Class of an element after reducing each coordinate once modulo p
  function automatic logic [1:0] elem_class(input logic [COEFF_W-1:0] lo,
                                            input logic [COEFF_W-1:0] hi);
    logic [COEFF_W-1:0] a;
    logic [COEFF_W-1:0] b;
    a = (lo >= GOLD_P) ? lo - GOLD_P : lo;
    b = (hi >= GOLD_P) ? hi - GOLD_P : hi;
    if (b != '0) return CLS_OTHER;
    if (a == '0) return CLS_ZERO;
    if (a == COEFF_W'(1)) return CLS_ONE;
    return CLS_OTHER;
  endfunction

  function automatic int lane_ahead(input int lane, input int step);
    return (lane % ROW_LANES + step) % ROW_LANES + ROW_LANES * (lane / ROW_LANES);
  endfunction

  // Helper bit the chi step demands: (not next1) and next2
  function automatic logic [1:0] chi_helper(input int lane, input int z);
    logic [1:0] b;
    logic [1:0] c;
    b = cls_mem[SEL_INPUT][lane_ahead(lane, 1) * LANE_BITS + z];
    c = cls_mem[SEL_INPUT][lane_ahead(lane, 2) * LANE_BITS + z];
    return (b ^ CLS_ONE) & c;
  endfunction

  // First failing constraint over the current class memories
  function automatic verdict_t chi_verdict();
    verdict_t v;
    int       i;
    int       lane;
    int       z;
    int       idx;
    v = PASS_VERDICT;
    for (i = 0; i < STATE_BITS; i++) begin
      if (cls_mem[SEL_INPUT][i] > CLS_ONE) return '{1'b0, FAIL_IN_BIN, IDX_W'(0)};
    end
    for (i = 0; i < STATE_BITS; i++) begin
      if (cls_mem[SEL_OUTPUT][i] > CLS_ONE) return '{1'b0, FAIL_OUT_BIN, IDX_W'(0)};
    end
    for (i = 0; i < STATE_BITS; i++) begin
      if (cls_mem[SEL_HELPER][i] > CLS_ONE) return '{1'b0, FAIL_HLP_BIN, IDX_W'(0)};
    end
    for (lane = 0; lane < NUM_LANES; lane++) begin
      for (z = 0; z < LANE_BITS; z++) begin
        idx = lane * LANE_BITS + z;
        if (cls_mem[SEL_HELPER][idx] != chi_helper(lane, z))
          return '{1'b0, FAIL_HLP_EQ, IDX_W'(idx)};
      end
    end
    for (idx = 0; idx < STATE_BITS; idx++) begin
      if (cls_mem[SEL_OUTPUT][idx] != (cls_mem[SEL_INPUT][idx] ^ cls_mem[SEL_HELPER][idx]))
        return '{1'b0, FAIL_XOR_EQ, IDX_W'(idx)};
    end
    return v;
  endfunction

  // Pick coordinates of a random encoding of the given class
  function automatic void pick_coeffs(input logic [1:0] cls,
                                      output logic [COEFF_W-1:0] lo,
                                      output logic [COEFF_W-1:0] hi);
    hi = $urandom_range(1) ? '0 : GOLD_P;
    if (cls == CLS_ZERO) begin
      lo = $urandom_range(1) ? '0 : GOLD_P;
    end else if (cls == CLS_ONE) begin
      lo = $urandom_range(1) ? COEFF_W'(1) : GOLD_P_PLUS;
    end else begin
      case ($urandom_range(3))
        0: lo = {$urandom, $urandom};
        1: lo = COEFF_W'(2) + COEFF_W'($urandom_range(1000));
        2: begin
          lo = {$urandom, $urandom};
          hi = {$urandom, $urandom};
        end
        default: lo = GOLD_P_PLUS + COEFF_W'(1) + COEFF_W'($urandom);
      endcase
    end
  endfunction

  // Drive one request, wait for its handshake, update the bench copy
  task automatic issue_req(input stim_row_t r);
    while ($urandom_range(99) < snd_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.func         <= r.func;
    req_ch.array_select <= r.sel;
    req_ch.position     <= r.pos;
    req_ch.coeff_low    <= r.lo;
    req_ch.coeff_high   <= r.hi;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (r.func == FUNC_CHECK) begin
      verdict_q.push_back(r.typed ? r.want : chi_verdict());
      n_checks++;
      n_items++;
    end else if (r.sel != SEL_NONE && r.pos < STATE_BITS) begin
      cls_mem[r.sel][r.pos] = elem_class(r.lo, r.hi);
      n_items++;
    end
  endtask

  task automatic send_load(input logic [SEL_W-1:0] sel, input int pos,
                           input logic [1:0] cls);
    stim_row_t r;
    r = '0;
    r.func = FUNC_LOAD;
    r.sel  = sel;
    r.pos  = IDX_W'(pos);
    pick_coeffs(cls, r.lo, r.hi);
    issue_req(r);
  endtask

  // Check request with random content in the ignored fields
  task automatic send_check();
    stim_row_t r;
    r      = '0;
    r.func = FUNC_CHECK;
    r.sel  = SEL_W'($urandom_range(3));
    r.pos  = IDX_W'($urandom_range(2047));
    r.lo   = {$urandom, $urandom};
    r.hi   = {$urandom, $urandom};
    issue_req(r);
  endtask

  // Rewrite one input bit and keep its row consistent at that bit
  task automatic reseed_bit();
    int row;
    int z;
    int lane;
    int idx;
    int c;
    row  = $urandom_range(ROW_LANES - 1);
    z    = $urandom_range(LANE_BITS - 1);
    lane = row * ROW_LANES + $urandom_range(ROW_LANES - 1);
    send_load(SEL_INPUT, lane * LANE_BITS + z, $urandom_range(1) ? CLS_ONE : CLS_ZERO);
    for (c = 0; c < ROW_LANES; c++) begin
      lane = row * ROW_LANES + c;
      send_load(SEL_HELPER, lane * LANE_BITS + z, chi_helper(lane, z));
    end
    for (c = 0; c < ROW_LANES; c++) begin
      idx = (row * ROW_LANES + c) * LANE_BITS + z;
      send_load(SEL_OUTPUT, idx, cls_mem[SEL_INPUT][idx] ^ cls_mem[SEL_HELPER][idx]);
    end
  endtask

  // Break one element and remember its old class for the undo
  task automatic inject_fault();
    fault_t           kind;
    logic [SEL_W-1:0] sel;
    int               pos;
    logic [1:0]       old_cls;
    logic [1:0]       cls;
    kind = fault_t'($urandom_range(5));
    pos  = $urandom_range(STATE_BITS - 1);
    case (kind)
      FLT_IN_NB, FLT_IN_FLIP:   sel = SEL_INPUT;
      FLT_OUT_NB, FLT_OUT_FLIP: sel = SEL_OUTPUT;
      default:                  sel = SEL_HELPER;
    endcase
    old_cls = cls_mem[sel][pos];
    if (kind inside {FLT_IN_NB, FLT_OUT_NB, FLT_HLP_NB} || old_cls > CLS_ONE) begin
      cls = CLS_OTHER;
    end else begin
      cls = old_cls ^ CLS_ONE;
    end
    undo_q.push_back('{sel, IDX_W'(pos), old_cls});
    send_load(sel, pos, cls);
  endtask

  // Hold requests until every pending check has answered
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  // Receiver: random back-pressure and response checking
  always @(posedge clk) begin
    verdict_t e;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (verdict_q.size() == 0) begin
          flag_error($sformatf("response with none pending: passed=%0d code=%0d idx=%0d",
                               rsp_ch.passed, rsp_ch.fail_code, rsp_ch.fail_index));
        end else begin
          e = verdict_q.pop_front();
          if (rsp_ch.passed !== e.passed || rsp_ch.fail_code !== e.code ||
              rsp_ch.fail_index !== e.fidx) begin
            flag_error($sformatf("check mismatch: exp passed=%0d code=%0d idx=%0d, got %0d %0d %0d",
                                 e.passed, e.code, e.fidx, rsp_ch.passed,
                                 rsp_ch.fail_code, rsp_ch.fail_index));
          end
        end
      end
    end
  end

  // Stimulus
  initial begin
    int        s;
    int        p;
    int        k;
    int        rand_base;
    int        phase;
    int        next_phase;
    undo_t     u;
    stim_row_t r;

    n_items  = 0;
    n_checks = 0;
    n_errors = 0;
    n_cycles = 0;
    snd_idle_pct  = 23;
    rcv_stall_pct = 69;
    rst                 <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.func         <= FUNC_LOAD;
    req_ch.array_select <= SEL_INPUT;
    req_ch.position     <= '0;
    req_ch.coeff_low    <= '0;
    req_ch.coeff_high   <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Write every element once: an all-zero witness satisfies chi
    for (s = SEL_INPUT; s <= SEL_HELPER; s++) begin
      for (p = 0; p < STATE_BITS; p++) send_load(SEL_W'(s), p, CLS_ZERO);
    end

    // Directed table, starting from the all-zero witness
    dir_tab.push_back('{FUNC_CHECK, SEL_INPUT, 11'd0, 64'd0, 64'd0, 1'b1, PASS_VERDICT});
    dir_tab.push_back('{FUNC_LOAD, SEL_INPUT, 11'd0, 64'd2, 64'd0, 1'b0, NO_VERDICT});
    dir_tab.push_back('{FUNC_CHECK, SEL_INPUT, 11'd0, 64'd0, 64'd0, 1'b1,
                        '{1'b0, FAIL_IN_BIN, IDX_W'(0)}});
    // p in both coordinates reads as zero
    dir_tab.push_back('{FUNC_LOAD, SEL_INPUT, 11'd0, GOLD_P, GOLD_P, 1'b0, NO_VERDICT});
    dir_tab.push_back('{FUNC_CHECK, SEL_INPUT, 11'd0, 64'd0, 64'd0, 1'b1, PASS_VERDICT});
    dir_tab.push_back('{FUNC_LOAD, SEL_OUTPUT, 11'd1599, '1, 64'd0, 1'b0, NO_VERDICT});
    dir_tab.push_back('{FUNC_CHECK, SEL_INPUT, 11'd0, 64'd0, 64'd0, 1'b1,
                        '{1'b0, FAIL_OUT_BIN, IDX_W'(0)}});
    dir_tab.push_back('{FUNC_LOAD, SEL_OUTPUT, 11'd1599, 64'd0, 64'd1, 1'b0, NO_VERDICT});
    dir_tab.push_back('{FUNC_CHECK, SEL_INPUT, 11'd0, 64'd0, 64'd0, 1'b1,
                        '{1'b0, FAIL_OUT_BIN, IDX_W'(0)}});
    // p + 1 reads as one: last element breaks the xor
    dir_tab.push_back('{FUNC_LOAD, SEL_OUTPUT, 11'd1599, GOLD_P_PLUS, 64'd0, 1'b0,
                        NO_VERDICT});
    dir_tab.push_back('{FUNC_CHECK, SEL_INPUT, 11'd0, 64'd0, 64'd0, 1'b1,
                        '{1'b0, FAIL_XOR_EQ, IDX_W'(1599)}});
    dir_tab.push_back('{FUNC_LOAD, SEL_HELPER, 11'd0, 64'd1, GOLD_P, 1'b0, NO_VERDICT});
    dir_tab.push_back('{FUNC_CHECK, SEL_INPUT, 11'd0, 64'd0, 64'd0, 1'b1,
                        '{1'b0, FAIL_HLP_EQ, IDX_W'(0)}});
    dir_tab.push_back('{FUNC_LOAD, SEL_HELPER, 11'd5, GOLD_P_PLUS + 64'd2,
                        GOLD_P_PLUS + 64'd2, 1'b0, NO_VERDICT});
    dir_tab.push_back('{FUNC_CHECK, SEL_INPUT, 11'd0, 64'd0, 64'd0, 1'b1,
                        '{1'b0, FAIL_HLP_BIN, IDX_W'(0)}});
    dir_tab.push_back('{FUNC_LOAD, SEL_HELPER, 11'd5, 64'd0, 64'd0, 1'b0, NO_VERDICT});
    dir_tab.push_back('{FUNC_LOAD, SEL_HELPER, 11'd0, 64'd0, 64'd0, 1'b0, NO_VERDICT});
    dir_tab.push_back('{FUNC_LOAD, SEL_OUTPUT, 11'd1599, 64'd0, 64'd0, 1'b0, NO_VERDICT});
    // Loads the block must drop: no array, position past the state
    dir_tab.push_back('{FUNC_LOAD, SEL_NONE, 11'd0, 64'd5, 64'd0, 1'b0, NO_VERDICT});
    dir_tab.push_back('{FUNC_LOAD, SEL_INPUT, 11'd2047, 64'd5, 64'd0, 1'b0, NO_VERDICT});
    dir_tab.push_back('{FUNC_LOAD, SEL_OUTPUT, 11'd1600, 64'd7, 64'd0, 1'b0, NO_VERDICT});
    dir_tab.push_back('{FUNC_CHECK, SEL_NONE, 11'd2047, '1, '1, 1'b1, PASS_VERDICT});
    dir_tab.push_back('{FUNC_LOAD, SEL_INPUT, 11'd64, 64'd1, 64'd0, 1'b0, NO_VERDICT});
    dir_tab.push_back('{FUNC_CHECK, SEL_INPUT, 11'd0, 64'd0, 64'd0, 1'b0, NO_VERDICT});
    dir_tab.push_back('{FUNC_LOAD, SEL_INPUT, 11'd64, 64'd0, 64'd0, 1'b0, NO_VERDICT});
    dir_tab.push_back('{FUNC_CHECK, SEL_INPUT, 11'd0, 64'd0, 64'd0, 1'b0, NO_VERDICT});
    foreach (dir_tab[i]) begin
      r = dir_tab[i];
      issue_req(r);
    end

    // Random episodes, with the idling profile stepping through three phases
    rand_base = n_items;
    phase     = 0;
    while ((n_items - rand_base < RAND_ITEMS || n_checks < MIN_CHECKS) &&
           n_checks < MAX_CHECKS) begin
      next_phase = (n_items - rand_base) * 3 / RAND_ITEMS;
      if (next_phase > 2) next_phase = 2;
      if (next_phase != phase) begin
        phase = next_phase;
        drain();
        snd_idle_pct  = (phase == 1) ? 69 : 0;
        rcv_stall_pct = (phase == 1) ? 23 : 0;
      end
      k = $urandom_range(99);
      if (k < 10) begin
        // Request the block must ignore
        r      = '0;
        r.func = FUNC_LOAD;
        r.lo   = {$urandom, $urandom};
        r.hi   = {$urandom, $urandom};
        if ($urandom_range(1)) begin
          r.sel = SEL_NONE;
          r.pos = IDX_W'($urandom_range(2047));
        end else begin
          r.sel = SEL_W'($urandom_range(3));
          r.pos = IDX_W'($urandom_range(2047, STATE_BITS));
        end
        issue_req(r);
      end else if (k < 55) begin
        repeat ($urandom_range(4, 1)) reseed_bit();
        send_check();
      end else begin
        repeat ($urandom_range(1)) reseed_bit();
        repeat ($urandom_range(3, 1)) inject_fault();
        send_check();
        // Undo the faults in reverse order
        while (undo_q.size() != 0) begin
          u = undo_q.pop_back();
          send_load(u.sel, u.pos, u.cls);
        end
      end
    end

    // Wait out the last responses and any trailing activity
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/kcc_pkg.sv
rtl/kcc_req_if.sv
rtl/kcc_rsp_if.sv
rtl/kcc_datapath.sv
rtl/kcc_ctrl.sv
rtl/keccak_chi_constraint_checker.sv
dv/keccak_chi_constraint_checker_tb.sv
